### rtl/mvn_pkg.sv
// shared types, constants and request codes for the vertex normal generator
// no dependencies
package mvn_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int POS_BITS_DEF     = 16;

	localparam int SLOT_W  = 10;
	localparam int COORD_W = 16;
	localparam int SUM_W   = 40;
	localparam int OUT_W   = 16;
	localparam int MAG_W   = 30;
	localparam int SQ_W    = 62;
	localparam int LEN_W   = 31;
	localparam int QUO_W   = 15;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_TRI   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_ZERO  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic [QUO_W-1:0] NORM_ONE = 15'd16384;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [12:0] {
		S_CLEAR   = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_TRI_RD  = 13'b0000000000100,
		S_TRI_MUL = 13'b0000000001000,
		S_ACC_RD  = 13'b0000000010000,
		S_ACC_WR  = 13'b0000000100000,
		S_SUM_RD  = 13'b0000001000000,
		S_SUM_CAP = 13'b0000010000000,
		S_NORM    = 13'b0000100000000,
		S_SQ      = 13'b0001000000000,
		S_ROOT    = 13'b0010000000000,
		S_DIV     = 13'b0100000000000,
		S_DONE    = 13'b1000000000000
	} state_t;

	typedef enum logic {
		RD_ROOT = 1'b0,
		RD_DIV  = 1'b1
	} rd_op_t;

	typedef struct packed {
		logic   start;
		rd_op_t op;
	} rd_req_t;

endpackage

### rtl/mesh_vertex_normal_generation_unit.sv
// a triangle reads its corners, forms the cross product and adds it to each corner's sum;
// a read normalizes (shift 1 bit/cycle, 31-step root, three 15-step divides) unless the sum
// is zero; a clear zeroes every sum; one request at a time
// reset: control clears at once, then a clearing pass zeroes all sums
// while in_stall is high; positions stay undefined until loaded
// uses mvn_pkg, mvn_ram, mvn_mul, mvn_rootdiv
module mesh_vertex_normal_generation_unit #(
	parameter int MAX_VERTICES = mvn_pkg::MAX_VERTICES_DEF,
	parameter int POS_BITS     = mvn_pkg::POS_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [mvn_pkg::SLOT_W-1:0]        slot,
	input  logic signed [mvn_pkg::COORD_W-1:0] pos_x,
	input  logic signed [mvn_pkg::COORD_W-1:0] pos_y,
	input  logic signed [mvn_pkg::COORD_W-1:0] pos_z,
	input  logic [mvn_pkg::SLOT_W-1:0]        corner_a,
	input  logic [mvn_pkg::SLOT_W-1:0]        corner_b,
	input  logic [mvn_pkg::SLOT_W-1:0]        corner_c,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [mvn_pkg::OUT_W-1:0]  normal_x,
	output logic signed [mvn_pkg::OUT_W-1:0]  normal_y,
	output logic signed [mvn_pkg::OUT_W-1:0]  normal_z
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int PW    = POS_BITS;
	localparam int DW    = PW + 1;                        // coordinate difference
	localparam int MW    = (DW > mvn_pkg::LEN_W) ? DW : mvn_pkg::LEN_W;
	localparam int PRW   = 2 * MW;
	localparam int CW    = 2 * DW + 1;                    // cross product
	localparam int SW    = mvn_pkg::SUM_W;
	localparam int ADW   = ((CW > SW) ? CW : SW) + 1;     // saturating add
	localparam int MAGW  = mvn_pkg::MAG_W;
	localparam int SQW   = mvn_pkg::SQ_W;
	localparam int LW    = mvn_pkg::LEN_W;
	localparam int QW    = mvn_pkg::QUO_W;
	localparam int OW    = mvn_pkg::OUT_W;

	// control state
	mvn_pkg::state_t state_q;
	logic [2:0]      step_q;
	logic            kick_q;
	logic            clr_resp_q;
	logic [AW-1:0]   clr_cnt_q;
	logic            out_valid_q;

	// request payload
	logic [AW-1:0]   slot_q;
	logic [AW-1:0]   corner_q [3];

	// triangle datapath
	logic signed [PW-1:0] pa_q    [3];
	logic signed [DW-1:0] u_q     [3];
	logic signed [DW-1:0] w_q     [3];
	logic signed [CW-1:0] cross_q [3];

	// read datapath
	logic [SW-1:0]  mag_q [3];
	logic [SW-1:0]  mm_q;
	logic           neg_q [3];
	logic [SQW-1:0] sq_acc_q;
	logic [LW-1:0]  len_q;

	// result
	logic [1:0]    res_status_q;
	logic [OW-1:0] res_n_q [3];
	logic [1:0]    status_q;
	logic [OW-1:0] nrm_q [3];

	logic accept;
	logic out_load;
	logic slot_ok;
	logic tri_ok;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (state_q != mvn_pkg::S_IDLE);
	assign out_load = (state_q == mvn_pkg::S_DONE) & (~out_valid_q | ~out_stall);

	assign slot_ok = 32'(slot) < 32'(MAX_VERTICES);
	assign tri_ok  = (32'(corner_a) < 32'(MAX_VERTICES)) &
		(32'(corner_b) < 32'(MAX_VERTICES)) & (32'(corner_c) < 32'(MAX_VERTICES));

	// corner picked by the step counter
	logic [AW-1:0] corner_sel;
	always_comb begin
		corner_sel = corner_q[2];
		for (int i = 0; i < 2; i++) begin
			if (step_q == 3'(i)) begin
				corner_sel = corner_q[i];
			end
		end
	end

	// ------------------------------------------------------------------
	// position store: coordinates reduced to POS_BITS on load
	// ------------------------------------------------------------------
	logic signed [PW-1:0] ld_x, ld_y, ld_z;
	logic [3*PW-1:0]      pos_rdata;
	logic signed [PW-1:0] rd_pos [3];

	assign ld_x = PW'(pos_x);
	assign ld_y = PW'(pos_y);
	assign ld_z = PW'(pos_z);

	mvn_ram #(
		.WIDTH(3 * PW),
		.DEPTH(MAX_VERTICES)
	) u_pos_ram (
		.clk  (clk),
		.we   (accept & (req_type == mvn_pkg::REQ_LOAD) & slot_ok),
		.waddr(AW'(slot)),
		.wdata({ld_z, ld_y, ld_x}),
		.raddr(corner_sel),
		.rdata(pos_rdata)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rd_pos[i] = $signed(pos_rdata[i*PW +: PW]);
		end
	end

	// ------------------------------------------------------------------
	// normal sum store: x, y, z sums side by side in one word
	// ------------------------------------------------------------------
	logic [3*SW-1:0]      sum_rdata;
	logic [3*SW-1:0]      sum_wdata;
	logic                 sum_we;
	logic [AW-1:0]        sum_waddr;
	logic [AW-1:0]        sum_raddr;
	logic signed [SW-1:0] sum_old [3];
	logic signed [SW-1:0] sum_new [3];
	logic signed [ADW-1:0] sum_wide [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_old[i]  = $signed(sum_rdata[i*SW +: SW]);
			sum_wide[i] = ADW'(sum_old[i]) + ADW'(cross_q[i]);
			if (sum_wide[i] > ADW'(mvn_pkg::SUM_MAX)) begin
				sum_new[i] = mvn_pkg::SUM_MAX;
			end else if (sum_wide[i] < ADW'(mvn_pkg::SUM_MIN)) begin
				sum_new[i] = mvn_pkg::SUM_MIN;
			end else begin
				sum_new[i] = SW'(sum_wide[i]);
			end
		end
		// clearing pass writes zeros, accumulation writes the saturated sums
		sum_we    = (state_q == mvn_pkg::S_CLEAR) | (state_q == mvn_pkg::S_ACC_WR);
		sum_waddr = (state_q == mvn_pkg::S_CLEAR) ? clr_cnt_q : corner_sel;
		sum_wdata = (state_q == mvn_pkg::S_CLEAR) ? '0 : {sum_new[2], sum_new[1], sum_new[0]};
		sum_raddr = (state_q == mvn_pkg::S_ACC_RD) ? corner_sel : slot_q;
	end

	mvn_ram #(
		.WIDTH(3 * SW),
		.DEPTH(MAX_VERTICES)
	) u_sum_ram (
		.clk  (clk),
		.we   (sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.raddr(sum_raddr),
		.rdata(sum_rdata)
	);

	// ------------------------------------------------------------------
	// shared multiplier: cross product terms, then squares of the read sums
	// ------------------------------------------------------------------
	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [PRW-1:0] prod;
	logic [MAGW-1:0]       mag_sel;

	always_comb begin
		mag_sel = mag_q[2][MAGW-1:0];
		for (int i = 0; i < 2; i++) begin
			if (step_q == 3'(i)) begin
				mag_sel = mag_q[i][MAGW-1:0];
			end
		end
		if (state_q == mvn_pkg::S_SQ) begin
			mul_a = MW'($signed({1'b0, mag_sel}));
			mul_b = mul_a;
		end else begin
			// cx = u1*w2 - u2*w1, cy = u2*w0 - u0*w2, cz = u0*w1 - u1*w0
			case (step_q)
				3'd0: begin
					mul_a = MW'(u_q[1]);
					mul_b = MW'(w_q[2]);
				end
				3'd1: begin
					mul_a = MW'(u_q[2]);
					mul_b = MW'(w_q[1]);
				end
				3'd2: begin
					mul_a = MW'(u_q[2]);
					mul_b = MW'(w_q[0]);
				end
				3'd3: begin
					mul_a = MW'(u_q[0]);
					mul_b = MW'(w_q[2]);
				end
				3'd4: begin
					mul_a = MW'(u_q[0]);
					mul_b = MW'(w_q[1]);
				end
				default: begin
					mul_a = MW'(u_q[1]);
					mul_b = MW'(w_q[0]);
				end
			endcase
		end
	end

	mvn_mul #(
		.W(MW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	// ------------------------------------------------------------------
	// shared root / divide unit
	// ------------------------------------------------------------------
	mvn_pkg::rd_req_t rd_req;
	logic             rd_done;
	logic [LW-1:0]    rd_result;
	logic [MAGW-1:0]  div_mag;
	logic [QW-1:0]    quo_clamped;

	always_comb begin
		rd_req.start = kick_q & ((state_q == mvn_pkg::S_ROOT) | (state_q == mvn_pkg::S_DIV));
		rd_req.op    = (state_q == mvn_pkg::S_ROOT) ? mvn_pkg::RD_ROOT : mvn_pkg::RD_DIV;
		div_mag      = mag_sel;
		quo_clamped  = (rd_result[QW-1:0] > mvn_pkg::NORM_ONE) ? mvn_pkg::NORM_ONE
			: rd_result[QW-1:0];
	end

	mvn_rootdiv u_rootdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (rd_req),
		.rad   (sq_acc_q),
		.mag   (div_mag),
		.den   (len_q),
		.done  (rd_done),
		.result(rd_result)
	);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mvn_pkg::S_CLEAR;
			step_q     <= '0;
			kick_q     <= 1'b0;
			clr_resp_q <= 1'b0;
			clr_cnt_q  <= '0;
		end else begin
			kick_q <= 1'b0;
			case (state_q)
				mvn_pkg::S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MAX_VERTICES - 1)) begin
						clr_cnt_q <= '0;
						// the pass after reset gives no result
						state_q   <= clr_resp_q ? mvn_pkg::S_DONE : mvn_pkg::S_IDLE;
					end
				end
				mvn_pkg::S_IDLE: begin
					step_q <= '0;
					if (accept) begin
						case (req_type)
							mvn_pkg::REQ_TRI: begin
								state_q <= tri_ok ? mvn_pkg::S_TRI_RD : mvn_pkg::S_DONE;
							end
							mvn_pkg::REQ_READ: begin
								state_q <= slot_ok ? mvn_pkg::S_SUM_RD : mvn_pkg::S_DONE;
							end
							mvn_pkg::REQ_CLEAR: begin
								state_q    <= mvn_pkg::S_CLEAR;
								clr_resp_q <= 1'b1;
							end
							default: begin
								state_q <= mvn_pkg::S_DONE;
							end
						endcase
					end
				end
				mvn_pkg::S_TRI_RD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) begin
						step_q  <= '0;
						state_q <= mvn_pkg::S_TRI_MUL;
					end
				end
				mvn_pkg::S_TRI_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						step_q  <= '0;
						state_q <= mvn_pkg::S_ACC_RD;
					end
				end
				mvn_pkg::S_ACC_RD: begin
					state_q <= mvn_pkg::S_ACC_WR;
				end
				mvn_pkg::S_ACC_WR: begin
					step_q  <= step_q + 3'd1;
					state_q <= (step_q == 3'd2) ? mvn_pkg::S_DONE : mvn_pkg::S_ACC_RD;
				end
				mvn_pkg::S_SUM_RD: begin
					state_q <= mvn_pkg::S_SUM_CAP;
				end
				mvn_pkg::S_SUM_CAP: begin
					state_q <= mvn_pkg::S_NORM;
				end
				mvn_pkg::S_NORM: begin
					if (mm_q == '0) begin
						state_q <= mvn_pkg::S_DONE;
					end else if (mm_q[SW-1:MAGW] == '0 && mm_q[MAGW-1]) begin
						step_q  <= '0;
						state_q <= mvn_pkg::S_SQ;
					end
				end
				mvn_pkg::S_SQ: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) begin
						step_q  <= '0;
						kick_q  <= 1'b1;
						state_q <= mvn_pkg::S_ROOT;
					end
				end
				mvn_pkg::S_ROOT: begin
					if (rd_done) begin
						kick_q  <= 1'b1;
						state_q <= mvn_pkg::S_DIV;
					end
				end
				mvn_pkg::S_DIV: begin
					if (rd_done) begin
						step_q <= step_q + 3'd1;
						if (step_q == 3'd2) begin
							state_q <= mvn_pkg::S_DONE;
						end else begin
							kick_q <= 1'b1;
						end
					end
				end
				mvn_pkg::S_DONE: begin
					if (out_load) begin
						clr_resp_q <= 1'b0;
						state_q    <= mvn_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= mvn_pkg::S_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q      <= AW'(slot);
			corner_q[0] <= AW'(corner_a);
			corner_q[1] <= AW'(corner_b);
			corner_q[2] <= AW'(corner_c);
			for (int i = 0; i < 3; i++) begin
				res_n_q[i] <= '0;
			end
			case (req_type)
				mvn_pkg::REQ_TRI:   res_status_q <= tri_ok ? mvn_pkg::STAT_OK : mvn_pkg::STAT_RANGE;
				mvn_pkg::REQ_CLEAR: res_status_q <= mvn_pkg::STAT_OK;
				default:            res_status_q <= slot_ok ? mvn_pkg::STAT_OK : mvn_pkg::STAT_RANGE;
			endcase
		end

		case (state_q)
			mvn_pkg::S_TRI_RD: begin
				// read data arrives in the cycle after its address
				for (int i = 0; i < 3; i++) begin
					case (step_q)
						3'd1:    pa_q[i] <= rd_pos[i];
						3'd2:    u_q[i]  <= DW'(rd_pos[i]) - DW'(pa_q[i]);
						3'd3:    w_q[i]  <= DW'(rd_pos[i]) - DW'(pa_q[i]);
						default: ;
					endcase
				end
			end
			mvn_pkg::S_TRI_MUL: begin
				case (step_q)
					3'd1:    cross_q[0] <= CW'(prod);
					3'd2:    cross_q[0] <= cross_q[0] - CW'(prod);
					3'd3:    cross_q[1] <= CW'(prod);
					3'd4:    cross_q[1] <= cross_q[1] - CW'(prod);
					3'd5:    cross_q[2] <= CW'(prod);
					3'd6:    cross_q[2] <= cross_q[2] - CW'(prod);
					default: ;
				endcase
			end
			mvn_pkg::S_SUM_CAP: begin
				logic [SW-1:0] m0, m1, m2, mx;
				m0 = sum_old[0][SW-1] ? (~sum_rdata[SW-1:0] + SW'(1)) : sum_rdata[SW-1:0];
				m1 = sum_old[1][SW-1] ? (~sum_rdata[2*SW-1:SW] + SW'(1))
					: sum_rdata[2*SW-1:SW];
				m2 = sum_old[2][SW-1] ? (~sum_rdata[3*SW-1:2*SW] + SW'(1))
					: sum_rdata[3*SW-1:2*SW];
				mx = (m0 > m1) ? m0 : m1;
				mx = (m2 > mx) ? m2 : mx;
				mag_q[0] <= m0;
				mag_q[1] <= m1;
				mag_q[2] <= m2;
				mm_q     <= mx;
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= sum_old[i][SW-1];
				end
			end
			mvn_pkg::S_NORM: begin
				// one bit per cycle until the largest magnitude sits in [2^29, 2^30)
				if (mm_q == '0) begin
					res_status_q <= mvn_pkg::STAT_ZERO;
				end else if (mm_q[SW-1:MAGW] != '0) begin
					mm_q <= mm_q >> 1;
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end else if (!mm_q[MAGW-1]) begin
					mm_q <= mm_q << 1;
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			mvn_pkg::S_SQ: begin
				if (step_q == 3'd1) begin
					sq_acc_q <= SQW'(prod);
				end else if (step_q != 3'd0) begin
					sq_acc_q <= sq_acc_q + SQW'(prod);
				end
			end
			mvn_pkg::S_ROOT: begin
				if (rd_done) begin
					len_q <= rd_result;
				end
			end
			mvn_pkg::S_DIV: begin
				if (rd_done) begin
					for (int i = 0; i < 3; i++) begin
						if (step_q == 3'(i)) begin
							res_n_q[i] <= neg_q[i] ? (OW'(0) - OW'(quo_clamped))
								: OW'(quo_clamped);
						end
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= res_status_q;
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= res_n_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign normal_x  = $signed(nrm_q[0]);
	assign normal_y  = $signed(nrm_q[1]);
	assign normal_z  = $signed(nrm_q[2]);

endmodule

### rtl/mvn_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/mvn_mul.sv
// shared signed multiplier with registered product
// no dependencies
module mvn_mul #(
	parameter int W = 31
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] prod
);

	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule

### rtl/mvn_rootdiv.sv
// iterative square root (two bits per step) and restoring divider (one quotient
// bit per step) sharing one compare and subtract unit; uses mvn_pkg
module mvn_rootdiv (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mvn_pkg::rd_req_t         req,
	input  logic [mvn_pkg::SQ_W-1:0]  rad,
	input  logic [mvn_pkg::MAG_W-1:0] mag,
	input  logic [mvn_pkg::LEN_W-1:0] den,
	output logic                     done,
	output logic [mvn_pkg::LEN_W-1:0] result
);

	localparam int RW    = mvn_pkg::SQ_W + 1;
	localparam int NUM_W = mvn_pkg::MAG_W + mvn_pkg::QUO_W;
	localparam int LW    = mvn_pkg::LEN_W;
	localparam int QW    = mvn_pkg::QUO_W;

	mvn_pkg::rd_op_t op_q;
	logic            busy_q;
	logic            done_q;
	logic [4:0]      cnt_q;
	logic [RW-1:0]   n_q;
	logic [RW-1:0]   r_q;
	logic [RW-1:0]   bit_q;
	logic [QW-1:0]   num_q;
	logic [QW-1:0]   q_q;
	logic [LW-1:0]   den_q;

	logic [RW-1:0]    opa;
	logic [RW-1:0]    opb;
	logic [RW:0]      diff;
	logic             ge;
	logic [NUM_W-1:0] numer;

	always_comb begin
		if (op_q == mvn_pkg::RD_ROOT) begin
			opa = n_q;
			opb = r_q + bit_q;
		end else begin
			opa = RW'({n_q[LW-1:0], num_q[QW-1]});
			opb = RW'(den_q);
		end
		diff  = {1'b0, opa} - {1'b0, opb};
		ge    = ~diff[RW];
		numer = {1'b0, mag, {(QW-1){1'b0}}} + NUM_W'(den >> 1);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= mvn_pkg::RD_ROOT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == mvn_pkg::RD_ROOT) ? 5'(mvn_pkg::SQ_W / 2 - 1)
					: 5'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.op == mvn_pkg::RD_ROOT) begin
				n_q   <= RW'(rad);
				r_q   <= '0;
				bit_q <= RW'(1) << (mvn_pkg::SQ_W - 2);
			end else begin
				n_q   <= RW'(numer[NUM_W-1:QW]);
				num_q <= numer[QW-1:0];
				q_q   <= '0;
				den_q <= den;
			end
		end else if (busy_q) begin
			if (op_q == mvn_pkg::RD_ROOT) begin
				if (ge) begin
					n_q <= diff[RW-1:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				n_q   <= ge ? RW'(diff[LW-1:0]) : RW'(opa[LW-1:0]);
				num_q <= num_q << 1;
				q_q   <= {q_q[QW-2:0], ge};
			end
		end
	end

	assign done   = done_q;
	assign result = (op_q == mvn_pkg::RD_ROOT) ? r_q[LW-1:0] : LW'(q_q);

endmodule

### verif/mesh_vertex_normal_generation_unit_test.sv
// self-checking testbench for mesh_vertex_normal_generation_unit: predicts each result
// from its own copy of the position store and normal sums and checks it field by field
// depends on mvn_pkg and the rtl of mesh_vertex_normal_generation_unit
module mesh_vertex_normal_generation_unit_test;

	localparam int NUM_SLOTS   = mvn_pkg::MAX_VERTICES_DEF;
	localparam int SLOT_W      = mvn_pkg::SLOT_W;
	localparam int COORD_W     = mvn_pkg::COORD_W;
	localparam int OUT_W       = mvn_pkg::OUT_W;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 200;
	localparam longint SAT_HI  = 64'sd549755813887;
	localparam longint SAT_LO  = -64'sd549755813888;

	typedef struct {
		logic [1:0]                req;
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] px, py, pz;
		logic [SLOT_W-1:0]         ca, cb, cc;
	} mesh_req_t;

	typedef struct {
		logic [1:0]              st;
		logic signed [OUT_W-1:0] nx, ny, nz;
	} normal_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = mvn_pkg::REQ_LOAD;
	logic [SLOT_W-1:0] slot = '0;
	logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [SLOT_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;

	// stimulus waiting to be sent and normals waiting to come back
	mesh_req_t   pending_reqs[$];
	normal_res_t expected_normals[$];

	// predictor state: positions and running area-weighted sums
	logic signed [COORD_W-1:0] pos_store[NUM_SLOTS][3];
	longint sum_store[NUM_SLOTS][3];

	// generator bookkeeping: which positions have been written
	bit loaded[NUM_SLOTS];
	int loaded_slots[$];
	int err_count = 0;
	int cycle_count = 0;

	always #10 clk = ~clk;

	mesh_vertex_normal_generation_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .slot(slot),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	function automatic longint sat_accum(longint a, longint b);
		longint r;
		r = a + b;
		if (r > SAT_HI) return SAT_HI;
		if (r < SAT_LO) return SAT_LO;
		return r;
	endfunction

	function automatic longint unsigned shift_mag(longint unsigned m, int sh);
		if (sh > 0) return m >> sh;
		if (sh < 0) return m << (-sh);
		return m;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [OUT_W-1:0] unit_comp(longint v, longint unsigned m,
			longint unsigned len);
		longint unsigned q;
		q = (m * 16384 + (len >> 1)) / len;
		if (q > 16384) q = 16384;
		if (v < 0) q = -q;
		return q[OUT_W-1:0];
	endfunction

	// applies one request to the predictor state and returns the normal it yields
	function automatic normal_res_t predict_normal(mesh_req_t r);
		normal_res_t res;
		longint u[3], w[3], cr[3], v[3];
		longint unsigned m[3], mm, len;
		int sh;
		int corners[3];
		res.st = mvn_pkg::STAT_OK;
		res.nx = '0; res.ny = '0; res.nz = '0;
		case (r.req)
			mvn_pkg::REQ_LOAD: begin
				if (int'(r.slot) >= NUM_SLOTS) res.st = mvn_pkg::STAT_RANGE;
				else begin
					pos_store[r.slot][0] = r.px;
					pos_store[r.slot][1] = r.py;
					pos_store[r.slot][2] = r.pz;
				end
			end
			mvn_pkg::REQ_TRI: begin
				corners[0] = int'(r.ca); corners[1] = int'(r.cb); corners[2] = int'(r.cc);
				if (corners[0] >= NUM_SLOTS || corners[1] >= NUM_SLOTS ||
						corners[2] >= NUM_SLOTS)
					res.st = mvn_pkg::STAT_RANGE;
				else begin
					for (int k = 0; k < 3; k++) begin
						u[k] = longint'(pos_store[corners[1]][k]) - pos_store[corners[0]][k];
						w[k] = longint'(pos_store[corners[2]][k]) - pos_store[corners[0]][k];
					end
					cr[0] = u[1] * w[2] - u[2] * w[1];
					cr[1] = u[2] * w[0] - u[0] * w[2];
					cr[2] = u[0] * w[1] - u[1] * w[0];
					for (int c = 0; c < 3; c++)
						for (int k = 0; k < 3; k++)
							sum_store[corners[c]][k] = sat_accum(sum_store[corners[c]][k], cr[k]);
				end
			end
			mvn_pkg::REQ_READ: begin
				if (int'(r.slot) >= NUM_SLOTS) res.st = mvn_pkg::STAT_RANGE;
				else begin
					mm = 0;
					for (int k = 0; k < 3; k++) begin
						v[k] = sum_store[r.slot][k];
						m[k] = (v[k] < 0) ? -v[k] : v[k];
						if (m[k] > mm) mm = m[k];
					end
					if (mm == 0) res.st = mvn_pkg::STAT_ZERO;
					else begin
						// common shift puts the largest magnitude in [2^29, 2^30)
						sh = 0;
						while (shift_mag(mm, sh) >= (64'd1 << 30)) sh++;
						while (shift_mag(mm, sh) < (64'd1 << 29)) sh--;
						for (int k = 0; k < 3; k++) m[k] = shift_mag(m[k], sh);
						len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
						res.nx = unit_comp(v[0], m[0], len);
						res.ny = unit_comp(v[1], m[1], len);
						res.nz = unit_comp(v[2], m[2], len);
					end
				end
			end
			default: begin
				for (int i = 0; i < NUM_SLOTS; i++)
					for (int k = 0; k < 3; k++) sum_store[i][k] = 0;
			end
		endcase
		return res;
	endfunction

	task automatic add_load(int s, int x, int y, int z);
		mesh_req_t r;
		r = '{mvn_pkg::REQ_LOAD, SLOT_W'(s), COORD_W'(x), COORD_W'(y), COORD_W'(z),
			SLOT_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom)};
		pending_reqs.push_back(r);
		if (!loaded[s]) begin
			loaded[s] = 1'b1;
			loaded_slots.push_back(s);
		end
	endtask

	task automatic add_tri(int a, int b, int c);
		mesh_req_t r;
		r = '{mvn_pkg::REQ_TRI, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), SLOT_W'(a), SLOT_W'(b), SLOT_W'(c)};
		pending_reqs.push_back(r);
	endtask

	task automatic add_read(int s);
		mesh_req_t r;
		r = '{mvn_pkg::REQ_READ, SLOT_W'(s), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom)};
		pending_reqs.push_back(r);
	endtask

	task automatic add_clear();
		mesh_req_t r;
		r = '{mvn_pkg::REQ_CLEAR, SLOT_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom)};
		pending_reqs.push_back(r);
	endtask

	function automatic int pick_loaded();
		return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
	endfunction

	function automatic int rand_coord();
		// mostly full range, sometimes small offsets for gentler sums
		if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 1023)) - 512;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// driver: one request in flight on the input side, gap drawn per request
	mesh_req_t cur_req;
	int in_gap = 0;
	bit in_burst = 1'b0;

	always @(posedge clk) begin
		logic next_valid;
		next_valid = in_valid;
		if (in_valid && in_stall === 1'b0) begin
			expected_normals.push_back(predict_normal(cur_req));
			next_valid = 1'b0;
			if ($urandom_range(0, 15) == 0) in_burst = ~in_burst;
			in_gap = in_burst ? 0 : int'($urandom_range(0, 10));
		end
		if (!next_valid && arst_n) begin
			if (in_gap > 0) in_gap--;
			else if (pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				next_valid = 1'b1;
				req_type <= cur_req.req;
				slot <= cur_req.slot;
				pos_x <= cur_req.px;
				pos_y <= cur_req.py;
				pos_z <= cur_req.pz;
				corner_a <= cur_req.ca;
				corner_b <= cur_req.cb;
				corner_c <= cur_req.cc;
			end
		end
		in_valid <= next_valid;
	end

	// monitor: checks against the oldest expected normal, stall drawn per request
	int out_hold = 0;
	bit out_burst = 1'b0;

	always @(posedge clk) begin
		normal_res_t exp_res;
		if (out_valid === 1'b1 && !out_stall) begin
			if (expected_normals.size() == 0) begin
				$error("result with no request pending: status %0d", status);
				err_count++;
			end else begin
				exp_res = expected_normals.pop_front();
				if (status !== exp_res.st) begin
					$error("status expected %0d got %0d", exp_res.st, status);
					err_count++;
				end
				if (normal_x !== exp_res.nx) begin
					$error("normal_x expected %0d got %0d", exp_res.nx, normal_x);
					err_count++;
				end
				if (normal_y !== exp_res.ny) begin
					$error("normal_y expected %0d got %0d", exp_res.ny, normal_y);
					err_count++;
				end
				if (normal_z !== exp_res.nz) begin
					$error("normal_z expected %0d got %0d", exp_res.nz, normal_z);
					err_count++;
				end
			end
			if ($urandom_range(0, 15) == 0) out_burst = ~out_burst;
			out_hold = out_burst ? 0 : int'($urandom_range(0, 10));
		end else if (out_hold > 0 && out_stall) begin
			out_hold--;
		end
		out_stall <= (out_hold > 0);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL mesh_vertex_normal_generation_unit");
			$finish;
		end
	end

	initial begin
		int a, b, c, kind, last_c[3];
		for (int i = 0; i < NUM_SLOTS; i++)
			for (int k = 0; k < 3; k++) sum_store[i][k] = 0;

		// directed: coordinate extremes, untouched read, repeated corners, clear
		add_load(0, -32768, -32768, -32768);
		add_load(1, 32767, -32768, -32768);
		add_load(2, -32768, 32767, -32768);
		add_load(1023, 32767, 32767, 32767);
		add_read(5);
		add_tri(0, 1, 2);
		add_read(0);
		add_read(1023);
		add_tri(0, 0, 1);
		add_tri(1023, 1, 2);
		add_read(1);
		add_read(2);
		add_read(1023);
		add_clear();
		add_read(0);
		add_load(3, 1, -2, 3);
		add_tri(3, 0, 1);
		add_read(3);
		add_read(0);

		// random: loads, triangles over loaded corners, reads mostly of touched slots, rare clears
		last_c = '{0, 1, 2};
		for (int n = 0; n < 1490; n++) begin
			kind = $urandom_range(0, 99);
			if (n == 800) begin
				// drive the sums of three vertices into saturation
				add_load(10, -32768, -32768, -32768);
				add_load(11, 32767, -32768, -32768);
				add_load(12, -32768, 32767, -32768);
				for (int k = 0; k < 140; k++) add_tri(10, 11, 12);
				add_read(10);
				add_read(12);
			end
			if (kind < 30) add_load($urandom_range(0, NUM_SLOTS - 1),
				rand_coord(), rand_coord(), rand_coord());
			else if (kind < 65) begin
				a = pick_loaded(); b = pick_loaded(); c = pick_loaded();
				if ($urandom_range(0, 19) == 0) c = a;
				add_tri(a, b, c);
				last_c = '{a, b, c};
			end else if (kind < 98) begin
				if ($urandom_range(0, 9) < 7) add_read(last_c[$urandom_range(0, 2)]);
				else add_read($urandom_range(0, NUM_SLOTS - 1));
			end else add_clear();
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || in_valid || expected_normals.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (err_count == 0 && expected_normals.size() == 0)
			$display("PASS mesh_vertex_normal_generation_unit");
		else
			$display("FAIL mesh_vertex_normal_generation_unit");
		$finish;
	end

endmodule

### filelist.f
rtl/mvn_pkg.sv
rtl/mvn_ram.sv
rtl/mvn_mul.sv
rtl/mvn_rootdiv.sv
rtl/mesh_vertex_normal_generation_unit.sv
verif/mesh_vertex_normal_generation_unit_test.sv
